### sv/bist_pkg.sv
package bist_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int CAP_W     = 7;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int OUT_W     = 1 + DATA_W + IDX_W + CNT_W + 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_SEARCH = 3'd4
  } req_t;

  typedef struct packed {
    logic capture;
    logic push;
    logic pop;
    logic clear;
    logic rd_top;
    logic rd_next;
    logic set_ok;
    logic take_data;
    logic take_idx;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic cnt_zero;
    logic can_push;
    logic match;
    logic scan_zero;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/bist_ram.sv
module bist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/bist_ctrl.sv
module bist_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  bist_pkg::dp_stat_t stat,
  output logic               in_ready,
  output bist_pkg::dp_cmd_t  cmd
);
  import bist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESULT;
        unique case (stat.req)
          REQ_PUSH: begin
            if (stat.can_push) begin
              cmd.push   = 1'b1;
              cmd.set_ok = 1'b1;
            end
          end
          REQ_POP: begin
            if (!stat.cnt_zero) begin
              cmd.rd_top = 1'b1;
              cmd.pop    = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
          REQ_PEEK: begin
            if (!stat.cnt_zero) begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_RDWAIT;
            end
          end
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.set_ok = 1'b1;
          end
          REQ_SEARCH: begin
            if (!stat.cnt_zero) begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.take_data = 1'b1;
        cmd.set_ok    = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_SCAN: begin
        priority if (stat.match) begin
          cmd.set_ok   = 1'b1;
          cmd.take_idx = 1'b1;
          state_nxt    = S_RESULT;
        end else if (stat.scan_zero) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  property p_match_ends_scan;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_SCAN && stat.match) |=> (state_r == S_RESULT);
  endproperty
  a_match_ends_scan: assert property (p_match_ends_scan)
    else $error("scan did not stop on a match");

endmodule

### sv/bist_dp.sv
module bist_dp #(
  parameter int DEPTH = bist_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bist_pkg::dp_cmd_t            cmd,
  output bist_pkg::dp_stat_t           stat,
  input  logic [bist_pkg::REQ_W-1:0]   in_req,
  input  logic [bist_pkg::DATA_W-1:0]  in_value,
  input  logic                         cfg_wr_en,
  input  logic [bist_pkg::CAP_W-1:0]   cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bist_pkg::OUT_W-1:0]   out_data
);
  import bist_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     scan_r;
  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] val_r;
  logic              ok_r;
  logic [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [CMPW-1:0]       cap_ext, cnt_ext, eff_cap;
  logic [CW-1:0]         cnt_dec;
  logic [AW-1:0]         top_addr, next_addr, rd_addr;
  logic [DATA_W-1:0]     rd_data;
  logic [IDX_W+AW-1:0]   idx_wide;
  logic [CNT_W+CW-1:0]   cnt_wide;
  logic                  is_full, is_empty;

  assign cap_ext   = CMPW'(cap_r);
  assign cnt_ext   = CMPW'(count_r);
  assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign cnt_dec   = count_r - CW'(1);
  assign top_addr  = cnt_dec[AW-1:0];
  assign next_addr = scan_r - AW'(1);
  assign rd_addr   = cmd.rd_next ? next_addr : top_addr;
  assign idx_wide  = {{IDX_W{1'b0}}, scan_r};
  assign cnt_wide  = {{CNT_W{1'b0}}, count_r};
  assign is_full   = (cnt_ext >= eff_cap);
  assign is_empty  = (count_r == '0);

  bist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (val_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.push) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= cnt_dec;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      val_r  <= in_value;
      ok_r   <= 1'b0;
      data_r <= '0;
      idx_r  <= '0;
    end
    if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
    if (cmd.take_data) begin
      data_r <= rd_data;
    end
    if (cmd.take_idx) begin
      idx_r <= idx_wide[IDX_W-1:0];
    end
    if (cmd.rd_top) begin
      scan_r <= top_addr;
    end else if (cmd.rd_next) begin
      scan_r <= next_addr;
    end
    if (cmd.out_load) begin
      out_data_r <= {is_full, is_empty, cnt_wide[CNT_W-1:0], idx_r, data_r, ok_r};
    end
  end

  assign stat.req       = req_t'(req_r);
  assign stat.cnt_zero  = is_empty;
  assign stat.can_push  = (cnt_ext < eff_cap);
  assign stat.match     = (rd_data == val_r);
  assign stat.scan_zero = (scan_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) cnt_ext <= DEPTH_C;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("entry count beyond depth");

  property p_count_hold;
    @(posedge clk) disable iff (!rst_n)
      !(cmd.push || cmd.pop || cmd.clear) |=> $stable(count_r);
  endproperty
  a_count_hold: assert property (p_count_hold)
    else $error("entry count moved without a command");

  property p_push_room;
    @(posedge clk) disable iff (!rst_n) cmd.push |-> (cnt_ext < eff_cap);
  endproperty
  a_push_room: assert property (p_push_room)
    else $error("push into a full stack");

endmodule

### sv/bounded_int_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with a top-down search. One request
// beat comes in on in_ (tuser carries the request kind, tdata the word or key)
// and exactly one result beat leaves on out_. Requests are handled one at a time
// by a controller over a single entry RAM with one write and one registered read
// port: push, clear, refused requests and unknown kinds pass from acceptance
// through an execute state and a result state, pop and peek add a read-wait
// state for the RAM read, and search adds a scan state that compares entries
// from the top down (at most the current count), one entry per cycle on
// the read port. A waiting result in the output register stalls only the
// result state. cfg_wr_data sets the capacity (effective capacity is the
// smaller of it and DEPTH); write it only while no request is in flight. The
// entry RAM needs no clearing after reset.
module bounded_int_stack_with_search #(
  parameter int DEPTH = bist_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // value
  input  logic [bist_pkg::DATA_W-1:0] in_tdata,
  // req_type
  input  logic [bist_pkg::REQ_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // ok, data, found_index, count, is_empty, is_full
  output logic [bist_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [bist_pkg::CAP_W-1:0]  cfg_wr_data
);
  import bist_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;

  assign in_fire = in_tvalid && in_tready;

  bist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  bist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_req      (in_tuser),
    .in_value    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

### tb/bounded_int_stack_with_search_tb.sv
module bounded_int_stack_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bist_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 80;
  localparam logic [REQ_W-1:0]  REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_BAD_HI = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX   = 32'h7fff_ffff;

  typedef struct packed {
    logic              is_full;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  found_index;
    logic [DATA_W-1:0] data;
    logic              ok;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic [REQ_W-1:0]  in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;

  logic [DATA_W-1:0] stack_words [DEPTH_DEF];
  int                stack_fill = 0;
  logic [CAP_W-1:0]  stack_cap  = CAP_RESET;
  answer_t           stack_answers_q [$];
  answer_t           got_answer;
  answer_t           want_answer;
  int                err_cnt         = 0;
  int                quiet_cycles    = 0;
  int                hold_off_cycles = 0;
  bit                steady_flow     = 1'b0;

  bounded_int_stack_with_search i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic answer_t predict_answer(input logic [REQ_W-1:0] kind,
                                             input logic [DATA_W-1:0] word);
    int      lim;
    bit      hit;
    answer_t a;
    lim = (stack_cap > DEPTH_DEF) ? DEPTH_DEF : int'(stack_cap);
    hit = 1'b0;
    a   = '0;
    case (kind)
      REQ_PUSH: begin
        if (stack_fill < lim) begin
          stack_words[stack_fill] = word;
          stack_fill++;
          a.ok = 1'b1;
        end
      end
      REQ_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          a.data = stack_words[stack_fill];
          a.ok   = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (stack_fill > 0) begin
          a.data = stack_words[stack_fill-1];
          a.ok   = 1'b1;
        end
      end
      REQ_CLEAR: begin
        stack_fill = 0;
        a.ok       = 1'b1;
      end
      REQ_SEARCH: begin
        for (int i = stack_fill - 1; i >= 0; i--) begin
          if (!hit && stack_words[i] == word) begin
            hit           = 1'b1;
            a.found_index = i[IDX_W-1:0];
          end
        end
        a.ok = hit;
      end
      default: ;
    endcase
    a.count    = stack_fill[CNT_W-1:0];
    a.is_empty = (stack_fill == 0);
    a.is_full  = (stack_fill >= lim);
    return a;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 7);
      3:       return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
      4:       return -$urandom_range(1, 8);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("mismatch in %s at %0t: expected %0h, got %0h", field, $realtime, want, got);
    err_cnt++;
  endtask

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    stack_answers_q.push_back(predict_answer(kind, word));
  endtask

  task automatic drain_requests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (stack_answers_q.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_requests();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    stack_cap    = cap;
  endtask

  task automatic send_random_request();
    int                pick;
    logic [DATA_W-1:0] word;
    logic [REQ_W-1:0]  kind;
    pick = $urandom_range(0, 99);
    word = random_word();
    if (pick < 42) begin
      kind = REQ_PUSH;
    end else if (pick < 60) begin
      kind = REQ_POP;
    end else if (pick < 70) begin
      kind = REQ_PEEK;
    end else if (pick < 92) begin
      kind = REQ_SEARCH;
      if (stack_fill > 0 && $urandom_range(0, 9) < 6) begin
        word = stack_words[$urandom_range(0, stack_fill - 1)];
      end
    end else if (pick < 95) begin
      kind = REQ_CLEAR;
    end else begin
      kind = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    end
    send_request(kind, word);
  endtask

  task automatic test_empty_stack();
    send_request(REQ_POP, $urandom());
    send_request(REQ_PEEK, $urandom());
    send_request(REQ_SEARCH, '0);
    send_request(REQ_CLEAR, $urandom());
    for (int k = REQ_BAD_LO; k <= REQ_BAD_HI; k++) begin
      send_request(k[REQ_W-1:0], $urandom());
    end
  endtask

  task automatic test_push_pop_extremes();
    send_request(REQ_PUSH, WORD_MIN);
    send_request(REQ_PUSH, WORD_MAX);
    send_request(REQ_PUSH, '0);
    send_request(REQ_PUSH, '1);
    send_request(REQ_PUSH, 32'h5555_5555);
    send_request(REQ_PUSH, 32'haaaa_aaaa);
    send_request(REQ_PUSH, WORD_MAX);
    send_request(REQ_PEEK, '0);
    send_request(REQ_SEARCH, WORD_MAX);
    send_request(REQ_SEARCH, WORD_MIN);
    send_request(REQ_SEARCH, 32'h1234_5678);
    for (int n = 0; n < 8; n++) begin
      send_request(REQ_POP, $urandom());
    end
    for (int k = REQ_BAD_LO; k <= REQ_BAD_HI; k++) begin
      send_request(k[REQ_W-1:0], $urandom());
    end
  endtask

  task automatic test_capacity_settings();
    write_capacity('1);
    for (int n = 0; n <= DEPTH_DEF; n++) begin
      send_request(REQ_PUSH, $urandom());
    end
    send_request(REQ_SEARCH, stack_words[0]);
    write_capacity(7'd3);
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_PEEK, $urandom());
    send_request(REQ_POP, $urandom());
    write_capacity('0);
    send_request(REQ_PUSH, $urandom());
    send_request(REQ_POP, $urandom());
    send_request(REQ_CLEAR, $urandom());
    send_request(REQ_PEEK, $urandom());
    send_request(REQ_PUSH, $urandom());
    write_capacity(7'd1);
    send_request(REQ_PUSH, WORD_MIN);
    send_request(REQ_PUSH, WORD_MAX);
    send_request(REQ_SEARCH, WORD_MIN);
    send_request(REQ_POP, $urandom());
    write_capacity(CAP_RESET);
  endtask

  task automatic test_output_stall();
    drain_requests();
    hold_off_cycles = 200;
    steady_flow     = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_random_request();
    end
    steady_flow = 1'b0;
    drain_requests();
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       cap = CAP_RESET;
        1:       cap = 7'd1;
        2:       cap = '1;
        3:       cap = '0;
        default: cap = CAP_W'($urandom_range(1, DEPTH_DEF));
      endcase
      write_capacity(cap);
      steady_flow = (p % 3 == 2);
      for (int n = 0; n < 100; n++) begin
        send_random_request();
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    int stall;
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_answer = answer_t'(out_tdata);
      if (stack_answers_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, got_answer.data);
      end else begin
        want_answer = stack_answers_q.pop_front();
        if (got_answer.ok !== want_answer.ok)
          report_mismatch("ok", DATA_W'(want_answer.ok), DATA_W'(got_answer.ok));
        if (got_answer.data !== want_answer.data)
          report_mismatch("data", want_answer.data, got_answer.data);
        if (got_answer.found_index !== want_answer.found_index)
          report_mismatch("found_index", DATA_W'(want_answer.found_index),
                          DATA_W'(got_answer.found_index));
        if (got_answer.count !== want_answer.count)
          report_mismatch("count", DATA_W'(want_answer.count), DATA_W'(got_answer.count));
        if (got_answer.is_empty !== want_answer.is_empty)
          report_mismatch("is_empty", DATA_W'(want_answer.is_empty),
                          DATA_W'(got_answer.is_empty));
        if (got_answer.is_full !== want_answer.is_full)
          report_mismatch("is_full", DATA_W'(want_answer.is_full),
                          DATA_W'(got_answer.is_full));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[bounded_int_stack_with_search] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_push_pop_extremes();
    test_capacity_settings();
    test_output_stall();
    test_random_traffic();
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && stack_answers_q.size() == 0) begin
      $display("[bounded_int_stack_with_search] OK");
    end else begin
      $display("[bounded_int_stack_with_search] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/bist_pkg.sv
sv/bist_ram.sv
sv/bist_ctrl.sv
sv/bist_dp.sv
sv/bounded_int_stack_with_search.sv
tb/bounded_int_stack_with_search_tb.sv
